>>> src/clcd_pkg.sv
// clcd_pkg: shared types, constants and helpers for the character LCD sequencer
// no dependencies; imported by every module of the block

package clcd_pkg;

  // text buffer geometry and wrap point
  localparam int BUFFER_DEPTH = 32;
  localparam int WRAP_COLUMN  = 15;
  localparam int BUF_AW       = $clog2(BUFFER_DEPTH);
  localparam int LEN_LIMIT    = (BUFFER_DEPTH > 63) ? 63 : BUFFER_DEPTH;

  // result queue depth, power of two, room for two results per item
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  // fixed LCD command bytes
  localparam logic [7:0] CMD_SET_DDRAM = 8'd128;
  localparam logic [7:0] ROW1_OFFSET   = 8'h40;
  localparam logic [7:0] CMD_CLEAR     = 8'b0000_0001;
  localparam logic [7:0] CMD_HOME      = 8'b0000_0010;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_POWER_UP_TICKS    = 3'd0,
    CFG_FUNCTION_SET_CMD  = 3'd1,
    CFG_DISPLAY_ON_CMD    = 3'd2,
    CFG_DISPLAY_CLEAR_CMD = 3'd3,
    CFG_ENTRY_MODE_CMD    = 3'd4
  } cfg_index_t;

  // request codes
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_PINS  = 4'd0,
    PH_WAIT  = 4'd1,
    PH_FSET  = 4'd2,
    PH_DON   = 4'd3,
    PH_DCLR  = 4'd4,
    PH_ENTRY = 4'd5,
    PH_IDLE  = 4'd6,
    PH_WRITE = 4'd7,
    PH_CLEAR = 4'd8
  } phase_t;

  typedef struct packed {
    logic [7:0] power_up_ticks;
    logic [7:0] function_set_cmd;
    logic [7:0] display_on_cmd;
    logic [7:0] display_clear_cmd;
    logic [7:0] entry_mode_cmd;
  } cfg_t;

  typedef struct packed {
    req_t       req_type;
    logic [4:0] char_index;
    logic [7:0] char_value;
    logic [5:0] text_length;
    logic       start_row;
    logic [5:0] start_column;
  } item_t;

  typedef struct packed {
    logic       result_kind;
    logic       status;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       is_idle;
    logic       last;
  } result_t;

  // results produced by one item, in order
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic [OUTQ_AW:0] level;
    logic             space_ok;
  } outq_status_t;

  // command write on the LCD bus
  function automatic result_t mk_cmd(input logic [7:0] b);
    result_t r;
    r = '0;
    r.result_kind = 1'b1;
    r.bus_byte    = b;
    return r;
  endfunction

  // data write on the LCD bus
  function automatic result_t mk_data(input logic [7:0] b);
    result_t r;
    r = '0;
    r.result_kind = 1'b1;
    r.reg_select  = 1'b1;
    r.bus_byte    = b;
    return r;
  endfunction

  // request status
  function automatic result_t mk_status(input logic rejected);
    result_t r;
    r = '0;
    r.status = rejected;
    return r;
  endfunction

endpackage

>>> src/clcd_seq.sv
// clcd_seq: phase state machine, text buffer and per-item result generation
// depends on clcd_pkg

module clcd_seq
  import clcd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output push_t push
);

  phase_t     phase, phase_next;
  logic [7:0] wait_count, wait_count_next;
  logic [5:0] write_length, write_length_next;
  logic [5:0] position, position_next;
  logic       wrapped, wrapped_next;

  logic [7:0] text_buf [BUFFER_DEPTH];
  logic       buf_we;
  logic [7:0] buf_rd;

  logic       at_end, at_wrap;
  logic [5:0] len_sat;
  result_t    r0, r1;
  logic [1:0] n;

  assign buf_rd  = text_buf[position[BUF_AW-1:0]];
  assign at_end  = (position == write_length);
  assign at_wrap = (position == 6'(WRAP_COLUMN)) && !wrapped;
  assign len_sat = (item.text_length > 6'(LEN_LIMIT)) ? 6'(LEN_LIMIT) : item.text_length;

  // next state
  always_comb begin
    phase_next        = phase;
    wait_count_next   = wait_count;
    write_length_next = write_length;
    position_next     = position;
    wrapped_next      = wrapped;
    buf_we            = 1'b0;
    if (fire) begin
      if (item.req_type == REQ_TICK) begin
        unique case (phase)
          PH_PINS:  phase_next = PH_WAIT;
          PH_WAIT: begin
            if (wait_count < cfg.power_up_ticks) begin
              wait_count_next = wait_count + 8'd1;
            end else begin
              wait_count_next = '0;
              phase_next      = PH_FSET;
            end
          end
          PH_FSET:  phase_next = PH_DON;
          PH_DON:   phase_next = PH_DCLR;
          PH_DCLR:  phase_next = PH_ENTRY;
          PH_ENTRY: phase_next = PH_IDLE;
          PH_WRITE: begin
            if (at_end) begin
              phase_next = PH_IDLE;
            end else if (at_wrap) begin
              wrapped_next = 1'b1;
            end else begin
              position_next = position + 6'd1;
            end
          end
          PH_CLEAR: begin
            if (position != '0) begin
              position_next = '0;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          default: ;
        endcase
      end else if (phase == PH_IDLE) begin
        unique case (item.req_type)
          REQ_LOAD:  buf_we = (int'(item.char_index) < BUFFER_DEPTH);
          REQ_WRITE: begin
            write_length_next = len_sat;
            position_next     = '0;
            wrapped_next      = 1'b0;
            phase_next        = PH_WRITE;
          end
          REQ_CLEAR: phase_next = PH_CLEAR;
          default: ;
        endcase
      end
    end
  end

  // results of the current item
  always_comb begin
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    if (fire) begin
      if (item.req_type == REQ_TICK) begin
        unique case (phase)
          PH_FSET:  begin r0 = mk_cmd(cfg.function_set_cmd);  n = 2'd1; end
          PH_DON:   begin r0 = mk_cmd(cfg.display_on_cmd);    n = 2'd1; end
          PH_DCLR:  begin r0 = mk_cmd(cfg.display_clear_cmd); n = 2'd1; end
          PH_ENTRY: begin r0 = mk_cmd(cfg.entry_mode_cmd);    n = 2'd1; end
          PH_WRITE: begin
            n = 2'd1;
            if (at_end) begin
              r0 = mk_cmd(CMD_SET_DDRAM + {2'b00, position} + 8'd1);
            end else if (at_wrap) begin
              r0 = mk_cmd(CMD_SET_DDRAM + ROW1_OFFSET);
            end else begin
              r0 = mk_data(buf_rd);
            end
          end
          PH_CLEAR: begin
            if (position != '0) begin
              r0 = mk_cmd(CMD_CLEAR);
              r1 = mk_cmd(CMD_HOME);
              n  = 2'd2;
            end
          end
          default: ;
        endcase
      end else if (phase != PH_IDLE) begin
        r0 = mk_status(1'b1);
        n  = 2'd1;
      end else begin
        r0 = mk_status(1'b0);
        n  = 2'd1;
        if (item.req_type == REQ_WRITE) begin
          r1 = mk_cmd(CMD_SET_DDRAM + (item.start_row ? ROW1_OFFSET : 8'd0)
                      + {2'b00, item.start_column});
          n  = 2'd2;
        end
      end
    end
    r0.is_idle = (phase_next == PH_IDLE);
    r1.is_idle = (phase_next == PH_IDLE);
    r0.last    = (n == 2'd1);
    r1.last    = 1'b1;
    push.count = n;
    push.r0    = r0;
    push.r1    = r1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PINS;
      wait_count   <= '0;
      write_length <= '0;
      position     <= '0;
      wrapped      <= 1'b0;
    end else begin
      phase        <= phase_next;
      wait_count   <= wait_count_next;
      write_length <= write_length_next;
      position     <= position_next;
      wrapped      <= wrapped_next;
    end
  end

  // text buffer, no reset
  always_ff @(posedge clk) begin
    if (buf_we) begin
      text_buf[BUF_AW'(item.char_index)] <= item.char_value;
    end
  end

endmodule

>>> src/clcd_outq.sv
// clcd_outq: small result queue taking up to two results a cycle, giving one while head_ready is high
// depends on clcd_pkg

module clcd_outq
  import clcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  push_t        push,
  output result_t      head,
  output logic         head_valid,
  input  logic         head_ready,
  output outq_status_t stat
);

  result_t          q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wr_ptr, rd_ptr;
  logic [OUTQ_AW:0]   level, level_next;
  logic               pop;

  assign head_valid    = (level != '0);
  assign head          = q[rd_ptr];
  assign pop           = head_valid && head_ready;
  assign level_next    = level + (OUTQ_AW+1)'(push.count) - (OUTQ_AW+1)'(pop);
  assign stat.level    = level;
  assign stat.space_ok = (int'(level) <= OUTQ_DEPTH - 2);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_AW'(push.count);
      rd_ptr <= rd_ptr + OUTQ_AW'(pop);
      level  <= level_next;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      q[wr_ptr + OUTQ_AW'(1)] <= push.r1;
    end
  end

endmodule

>>> src/char_lcd_init_and_write_sequencer_core.sv
// Flow: a transaction taken on s_axis is held in the input register and processed
//   once the result queue has room; its results reach m_axis through that queue.
// Throughput: one item per cycle while results drain; an item with two results
//   (write start, clear and home) sends them in turn on the single m_axis port.
// Reset: synchronous rst clears control state and loads register defaults;
//   the text buffer keeps its contents and holds garbage until loaded.

module char_lcd_init_and_write_sequencer_core
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] char_index, [12:5] char_value, [18:13] text_length,
  // [19] start_row, [25:20] start_column, [31:26] zero
  input  logic [31:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] status, [8:1] bus_byte, [9] is_idle, [15:10] zero
  output logic [15:0] m_axis_tdata,
  // [0] result_kind, [1] reg_select
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t         cfg;
  item_t        item_q;
  logic         item_valid;
  logic         fire;
  push_t        push;
  result_t      head;
  outq_status_t outq_stat;

  assign fire          = item_valid && outq_stat.space_ok;
  assign s_axis_tready = !item_valid || fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_up_ticks    <= 8'd20;
      cfg.function_set_cmd  <= 8'd56;
      cfg.display_on_cmd    <= 8'd12;
      cfg.display_clear_cmd <= 8'd1;
      cfg.entry_mode_cmd    <= 8'd6;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_POWER_UP_TICKS:    cfg.power_up_ticks    <= cfg_data;
        CFG_FUNCTION_SET_CMD:  cfg.function_set_cmd  <= cfg_data;
        CFG_DISPLAY_ON_CMD:    cfg.display_on_cmd    <= cfg_data;
        CFG_DISPLAY_CLEAR_CMD: cfg.display_clear_cmd <= cfg_data;
        CFG_ENTRY_MODE_CMD:    cfg.entry_mode_cmd    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.req_type     <= req_t'(s_axis_tuser);
      item_q.char_index   <= s_axis_tdata[4:0];
      item_q.char_value   <= s_axis_tdata[12:5];
      item_q.text_length  <= s_axis_tdata[18:13];
      item_q.start_row    <= s_axis_tdata[19];
      item_q.start_column <= s_axis_tdata[25:20];
    end
  end

  clcd_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item_q),
    .cfg  (cfg),
    .push (push)
  );

  clcd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .head       (head),
    .head_valid (m_axis_tvalid),
    .head_ready (m_axis_tready),
    .stat       (outq_stat)
  );

  // output packing
  assign m_axis_tdata = {6'b0, head.is_idle, head.bus_byte, head.status};
  assign m_axis_tuser = {head.reg_select, head.result_kind};
  assign m_axis_tlast = head.last;

  // queue never overfills
  a_outq_level: assert property (@(posedge clk) disable iff (rst)
    int'(outq_stat.level) <= OUTQ_DEPTH)
    else $error("result queue overfilled");

  // a rejected request never reports the block idle
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0] && m_axis_tdata[0]) |-> !m_axis_tdata[9])
    else $error("rejected request marked idle");

  // a data byte on the bus leaves the block in a write run
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && !m_axis_tdata[9]))
    else $error("data write marked idle or not a bus write");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !m_axis_tvalid)
    else $error("result present after reset");

endmodule
